// ===== rtl/pixel_to_ray_direction_top_macros.svh =====
// Assertion macros shared by the pixel-to-ray RTL.
`ifndef PIXEL_TO_RAY_DIRECTION_TOP_MACROS_SVH
`define PIXEL_TO_RAY_DIRECTION_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define PTRD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define PTRD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PTRD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PTRD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/ptrd_pkg.sv =====
// Shared types, constants and helpers of the pixel-to-ray block.
package ptrd_pkg;

    localparam int COORD_W  = 10;
    localparam int SCALE_W  = 16;
    localparam int POS_FRAC = 15;
    localparam int CFG_W    = 16;
    localparam int PROD_W   = 31;
    localparam int SQ_W     = 62;

    localparam logic [SCALE_W-1:0] SCALE_ONE = 16'h8000;
    localparam logic [SCALE_W-1:0] POS_ONE   = 16'h8000;
    localparam logic [PROD_W-1:0]  FWD_ONE   = 31'h4000_0000;

    typedef enum logic [1:0] {
        REG_WIDTH   = 2'd0,
        REG_HEIGHT  = 2'd1,
        REG_SCALE_Y = 2'd2,
        REG_SCALE_Z = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic               sat;
        logic               neg;
        logic [COORD_W-1:0] mag;
        logic [COORD_W-1:0] ext;
    } t_pos_prep;

    // Fold the pixel about the screen center and flag saturation.
    function automatic t_pos_prep pos_prep(input logic [COORD_W-1:0] p,
                                           input logic [COORD_W-1:0] extent);
        t_pos_prep        res;
        logic [COORD_W-1:0] w;
        logic [COORD_W:0]   twice;
        logic [COORD_W:0]   mag;
        w     = (extent == '0) ? COORD_W'(1) : extent;
        twice = {p, 1'b0};
        if (twice >= {1'b0, w}) begin
            mag     = twice - {1'b0, w};
            res.neg = 1'b0;
        end else begin
            mag     = {1'b0, w} - twice;
            res.neg = 1'b1;
        end
        res.sat = (mag >= {1'b0, w});
        res.mag = res.sat ? '0 : mag[COORD_W-1:0];
        res.ext = w;
        return res;
    endfunction

endpackage

// ===== rtl/ptrd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module ptrd_div #(
    parameter int N_W   = 10,
    parameter int STEPS = 15,
    parameter int SB_W  = 1
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [N_W-1:0]                     i_rem,
    input  logic [STEPS-1:0]                   i_low,
    input  logic [N_W-1:0]                     i_div,
    input  logic [(SB_W > 0 ? SB_W : 1)-1:0]   i_sb,
    output logic [STEPS-1:0]                   o_quo,
    output logic [(SB_W > 0 ? SB_W : 1)-1:0]   o_sb
);

    localparam int SBX = (SB_W > 0) ? SB_W : 1;

    logic [N_W-1:0]   r_rem [STEPS-1];
    logic [STEPS-1:0] r_low [STEPS-1];
    logic [N_W-1:0]   r_div [STEPS-1];
    logic [STEPS-1:0] r_quo [STEPS];
    logic [SBX-1:0]   r_sb  [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        logic [N_W-1:0]   rem_in;
        logic [STEPS-1:0] low_in;
        logic [N_W-1:0]   div_in;
        logic [STEPS-1:0] quo_in;
        logic [SBX-1:0]   sb_in;
        logic [N_W:0]     t;
        logic [N_W:0]     diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in = i_rem;
            assign low_in = i_low;
            assign div_in = i_div;
            assign quo_in = '0;
            assign sb_in  = i_sb;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign div_in = r_div[k-1];
            assign quo_in = r_quo[k-1];
            assign sb_in  = r_sb[k-1];
        end

        assign t    = {rem_in, low_in[STEPS-1]};
        assign diff = t - {1'b0, div_in};
        assign ge   = (t >= {1'b0, div_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= {quo_in[STEPS-2:0], ge};
                r_sb[k]  <= sb_in;
            end
        end

        if (k < STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? diff[N_W-1:0] : t[N_W-1:0];
                    r_low[k] <= {low_in[STEPS-2:0], 1'b0};
                    r_div[k] <= div_in;
                end
            end
        end
    end

    assign o_quo = r_quo[STEPS-1];
    assign o_sb  = (SB_W > 0) ? r_sb[STEPS-1] : '0;

endmodule

// ===== rtl/ptrd_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module ptrd_sqrt #(
    parameter int R_W  = 31,
    parameter int SB_W = 64
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [2*R_W-1:0]  i_val,
    input  logic [SB_W-1:0]   i_sb,
    output logic [R_W-1:0]    o_root,
    output logic [SB_W-1:0]   o_sb
);

    logic [R_W:0]     r_rem  [R_W-1];
    logic [2*R_W-1:0] r_val  [R_W-1];
    logic [R_W-1:0]   r_root [R_W];
    logic [SB_W-1:0]  r_sb   [R_W];

    for (genvar k = 0; k < R_W; k++) begin : g_stage
        logic [R_W:0]     rem_in;
        logic [2*R_W-1:0] val_in;
        logic [R_W-1:0]   root_in;
        logic [SB_W-1:0]  sb_in;
        logic [R_W+2:0]   t;
        logic [R_W+2:0]   trial;
        logic [R_W+2:0]   diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign val_in  = i_val;
            assign root_in = '0;
            assign sb_in   = i_sb;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign val_in  = r_val[k-1];
            assign root_in = r_root[k-1];
            assign sb_in   = r_sb[k-1];
        end

        assign t     = {rem_in, val_in[2*R_W-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign diff  = t - trial;
        assign ge    = (t >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= {root_in[R_W-2:0], ge};
                r_sb[k]   <= sb_in;
            end
        end

        if (k < R_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? diff[R_W:0] : t[R_W:0];
                    r_val[k] <= {val_in[2*R_W-3:0], 2'b00};
                end
            end
        end
    end

    assign o_root = r_root[R_W-1];
    assign o_sb   = r_sb[R_W-1];

endmodule

// ===== rtl/pixel_to_ray_direction_top.sv =====
// Top level of the pinhole-camera ray generator: pixel in, unit ray out.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+-----------------------------------
//  pixel   | in        | i_valid / o_ready   | i_pixel_x, i_pixel_y
//  ray     | out       | o_valid / i_ready   | o_dir_x, o_dir_y, o_dir_z
//  config  | in        | i_cfg_we            | i_cfg_idx, i_cfg_data
//
//  One word enters per cycle while the output is not stalled; a ray passes
//  through 15 screen divide stages, multiply, square, sum, 31 square root
//  stages, FRAC_BITS + 1 normalize divide stages and the output register.
//  All stages advance together; a stalled output freezes the whole pipe, so
//  nothing is dropped or repeated and o_ready follows !o_valid || i_ready.
//  Reset (synchronous, active low) clears the valid chain and loads the
//  default viewport and scales.
module pixel_to_ray_direction_top #(
    parameter int COORD_MAX = 1023,
    parameter int FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ptrd_pkg::COORD_W-1:0]      i_pixel_x,
    input  logic [ptrd_pkg::COORD_W-1:0]      i_pixel_y,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [FRAC_BITS:0]                o_dir_x,
    output logic signed [FRAC_BITS+1:0]       o_dir_y,
    output logic signed [FRAC_BITS+1:0]       o_dir_z,
    input  logic                              i_cfg_we,
    input  ptrd_pkg::t_cfg_idx                i_cfg_idx,
    input  logic [ptrd_pkg::CFG_W-1:0]        i_cfg_data
);

    import ptrd_pkg::*;

    `include "pixel_to_ray_direction_top_macros.svh"

    // Stage map: screen divide, multiply, square, sum, root, normalize, out.
    localparam int S_MUL  = POS_FRAC;
    localparam int S_SQ   = S_MUL + 1;
    localparam int S_SUM  = S_SQ + 1;
    localparam int S_ROOT = S_SUM + PROD_W;
    localparam int S_NORM = S_ROOT + FRAC_BITS + 1;
    localparam int LAT    = S_NORM + 2;
    localparam int DW     = PROD_W + FRAC_BITS + 1;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam logic [COORD_W-1:0] PIX_MAX =
        (COORD_MAX > 1023) ? COORD_W'(1023) : COORD_W'(COORD_MAX);
    localparam logic [Q_W-1:0] X_ONE = Q_W'(1) << FRAC_BITS;
    localparam logic signed [Q_W:0] Y_ONE = (Q_W+1)'(1) << FRAC_BITS;

    // Configuration registers.
    logic [COORD_W-1:0] r_width, r_height;
    logic [SCALE_W-1:0] r_scale_y, r_scale_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= COORD_W'(80);
            r_height  <= COORD_W'(24);
            r_scale_y <= SCALE_W'(28378);
            r_scale_z <= SCALE_W'(16384);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:   r_width   <= i_cfg_data[COORD_W-1:0];
                REG_HEIGHT:  r_height  <= i_cfg_data[COORD_W-1:0];
                REG_SCALE_Y: r_scale_y <= i_cfg_data;
                REG_SCALE_Z: r_scale_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipe enable: advance whenever the output slot is free or being drained.
    logic en;
    logic r_vld [LAT];

    assign en      = !o_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Screen position: clamp the pixel, fold about center, divide by extent.
    logic [COORD_W-1:0] px_c, py_c;
    t_pos_prep          prep_x, prep_y;
    logic [POS_FRAC-1:0] quo_x, quo_y;
    logic [1:0]          sb_x, sb_y;

    assign px_c   = (i_pixel_x > PIX_MAX) ? PIX_MAX : i_pixel_x;
    assign py_c   = (i_pixel_y > PIX_MAX) ? PIX_MAX : i_pixel_y;
    assign prep_x = pos_prep(px_c, r_width);
    assign prep_y = pos_prep(py_c, r_height);

    ptrd_div #(.N_W(COORD_W), .STEPS(POS_FRAC), .SB_W(2)) u_div_sx (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rem (prep_x.mag),
        .i_low ({{(POS_FRAC-COORD_W+1){1'b0}}, prep_x.ext[COORD_W-1:1]}),
        .i_div (prep_x.ext),
        .i_sb  ({prep_x.neg, prep_x.sat}),
        .o_quo (quo_x),
        .o_sb  (sb_x)
    );

    ptrd_div #(.N_W(COORD_W), .STEPS(POS_FRAC), .SB_W(2)) u_div_sy (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rem (prep_y.mag),
        .i_low ({{(POS_FRAC-COORD_W+1){1'b0}}, prep_y.ext[COORD_W-1:1]}),
        .i_div (prep_y.ext),
        .i_sb  ({prep_y.neg, prep_y.sat}),
        .o_quo (quo_y),
        .o_sb  (sb_y)
    );

    // Scale the screen position into the image plane.
    logic [SCALE_W-1:0] sx, sy, ky, kz;
    logic [2*SCALE_W-1:0] prod_a, prod_b;

    assign sx = sb_x[0] ? POS_ONE : {1'b0, quo_x};
    assign sy = sb_y[0] ? POS_ONE : {1'b0, quo_y};
    assign ky = (r_scale_y > SCALE_ONE) ? SCALE_ONE : r_scale_y;
    assign kz = (r_scale_z > SCALE_ONE) ? SCALE_ONE : r_scale_z;
    assign prod_a = {{SCALE_W{1'b0}}, sx} * {{SCALE_W{1'b0}}, ky};
    assign prod_b = {{SCALE_W{1'b0}}, sy} * {{SCALE_W{1'b0}}, kz};

    logic [PROD_W-1:0] r_a, r_b, r_a_s, r_b_s, r_a_t, r_b_t;
    logic              r_ny, r_nz, r_ny_s, r_nz_s, r_ny_t, r_nz_t;
    logic [SQ_W-1:0]   r_a2, r_b2, r_sum;
    logic [2*PROD_W-1:0] sq_a, sq_b;

    assign sq_a = {{PROD_W{1'b0}}, r_a} * {{PROD_W{1'b0}}, r_a};
    assign sq_b = {{PROD_W{1'b0}}, r_b} * {{PROD_W{1'b0}}, r_b};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a    <= prod_a[PROD_W-1:0];
            r_b    <= prod_b[PROD_W-1:0];
            r_ny   <= sb_x[1];
            r_nz   <= sb_y[1];
            r_a2   <= sq_a;
            r_b2   <= sq_b;
            r_a_s  <= r_a;
            r_b_s  <= r_b;
            r_ny_s <= r_ny;
            r_nz_s <= r_nz;
            r_sum  <= (SQ_W'(1) << 60) + r_a2 + r_b2;
            r_a_t  <= r_a_s;
            r_b_t  <= r_b_s;
            r_ny_t <= r_ny_s;
            r_nz_t <= r_nz_s;
        end
    end

    // Vector length.
    logic [PROD_W-1:0]     root;
    logic [2*PROD_W+1:0]   sb_root;

    ptrd_sqrt #(.R_W(PROD_W), .SB_W(2*PROD_W+2)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r_sum),
        .i_sb   ({r_ny_t, r_nz_t, r_a_t, r_b_t}),
        .o_root (root),
        .o_sb   (sb_root)
    );

    // Normalize: round-half-up of c * 2^FRAC_BITS / n for each component.
    logic [PROD_W-1:0] c_a, c_b;
    logic [DW-1:0]     half_n, d_x, d_y, d_z;
    logic [Q_W-1:0]    q_x, q_y, q_z;
    logic              ny_n, nz_n;

    assign c_a    = sb_root[2*PROD_W-1:PROD_W];
    assign c_b    = sb_root[PROD_W-1:0];
    assign half_n = {{(DW-PROD_W+1){1'b0}}, root[PROD_W-1:1]};
    assign d_x    = {FWD_ONE, {FRAC_BITS{1'b0}}} + half_n;
    assign d_y    = {c_a, {FRAC_BITS{1'b0}}} + half_n;
    assign d_z    = {c_b, {FRAC_BITS{1'b0}}} + half_n;

    ptrd_div #(.N_W(PROD_W), .STEPS(Q_W), .SB_W(0)) u_div_nx (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rem (d_x[DW-1:Q_W]),
        .i_low (d_x[Q_W-1:0]),
        .i_div (root),
        .i_sb  (1'b0),
        .o_quo (q_x),
        .o_sb  ()
    );

    ptrd_div #(.N_W(PROD_W), .STEPS(Q_W), .SB_W(1)) u_div_ny (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rem (d_y[DW-1:Q_W]),
        .i_low (d_y[Q_W-1:0]),
        .i_div (root),
        .i_sb  (sb_root[2*PROD_W+1]),
        .o_quo (q_y),
        .o_sb  (ny_n)
    );

    ptrd_div #(.N_W(PROD_W), .STEPS(Q_W), .SB_W(1)) u_div_nz (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rem (d_z[DW-1:Q_W]),
        .i_low (d_z[Q_W-1:0]),
        .i_div (root),
        .i_sb  (sb_root[2*PROD_W]),
        .o_quo (q_z),
        .o_sb  (nz_n)
    );

    // Output register: apply signs after rounding so rounding stays symmetric.
    logic [Q_W-1:0] r_dir_x;
    logic [Q_W:0]   r_dir_y, r_dir_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dir_x <= q_x;
            r_dir_y <= ny_n ? -{1'b0, q_y} : {1'b0, q_y};
            r_dir_z <= nz_n ? -{1'b0, q_z} : {1'b0, q_z};
        end
    end

    assign o_dir_x = r_dir_x;
    assign o_dir_y = r_dir_y;
    assign o_dir_z = r_dir_z;

    `PTRD_ASSERT_IMP(a_root_norm, i_clk, i_rst_n, r_vld[S_ROOT],
                     root[PROD_W-1] == 1'b1, "ray length below one")
    `PTRD_ASSERT_IMP(a_fwd_range, i_clk, i_rst_n, o_valid,
                     (o_dir_x != '0) && (o_dir_x <= X_ONE),
                     "forward component out of range")
    `PTRD_ASSERT_IMP(a_side_range, i_clk, i_rst_n, o_valid,
                     (o_dir_y <= Y_ONE) && (o_dir_y >= -Y_ONE) &&
                     (o_dir_z <= Y_ONE) && (o_dir_z >= -Y_ONE),
                     "side component out of range")
    `PTRD_ASSERT_NXT(a_enter, i_clk, i_rst_n, i_valid && o_ready, r_vld[0],
                     "accepted pixel lost at entry")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench of the pixel-to-ray direction generator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ptrd_pkg::*;

    localparam int COORD_MAX = 1023;
    localparam int FRAC_BITS = 14;
    localparam int DRAIN_CYCLES = 51 + FRAC_BITS + 10;
    localparam int STALL_LIMIT = 20000;
    localparam int N_PHASES = 9;
    localparam int RANDOM_PER_PHASE = 170;

    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
    } pixel_t;

    typedef struct packed {
        logic [FRAC_BITS:0]   dx;
        logic [FRAC_BITS+1:0] dy;
        logic [FRAC_BITS+1:0] dz;
    } ray_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [COORD_W-1:0]   i_pixel_x;
    logic [COORD_W-1:0]   i_pixel_y;
    logic                 o_valid;
    logic                 i_ready;
    logic [FRAC_BITS:0]   o_dir_x;
    logic signed [FRAC_BITS+1:0] o_dir_y;
    logic signed [FRAC_BITS+1:0] o_dir_z;
    logic                 i_cfg_we;
    t_cfg_idx             i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    pixel_to_ray_direction_top #(.COORD_MAX(COORD_MAX), .FRAC_BITS(FRAC_BITS)) dut (.*);

    // Mirror of the viewport and scale registers.
    int unsigned view_w, view_h, plane_y, plane_z;

    pixel_t pixel_q[$];
    ray_t   ray_q[$];
    int     fail_count = 0;
    int     sender_idle_pct = 0;
    int     receiver_idle_pct = 0;
    int     quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Integer square root, floor.
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Screen position in Q1.15, saturated to one, with its sign.
    function automatic longint unsigned fold_pos(int unsigned p, int unsigned ext,
                                                 output bit neg);
        longint unsigned w = (ext == 0) ? 1 : ext;
        longint unsigned twice = 2 * p;
        longint unsigned mag;
        neg = (twice < w);
        mag = neg ? w - twice : twice - w;
        if (mag >= w) return 64'd32768;
        return ((mag << 15) + w / 2) / w;
    endfunction

    function automatic longint unsigned norm_mag(longint unsigned c, longint unsigned n);
        return ((c << FRAC_BITS) + n / 2) / n;
    endfunction

    function automatic ray_t predict_ray(pixel_t pix);
        ray_t r;
        int unsigned px = (pix.px > COORD_MAX) ? COORD_MAX : pix.px;
        int unsigned py = (pix.py > COORD_MAX) ? COORD_MAX : pix.py;
        longint unsigned ky = (plane_y > 32768) ? 32768 : plane_y;
        longint unsigned kz = (plane_z > 32768) ? 32768 : plane_z;
        longint unsigned sx, sy, a, b, n, one, my, mz;
        bit ny, nz;
        sx = fold_pos(px, view_w, ny);
        sy = fold_pos(py, view_h, nz);
        a = sx * ky;
        b = sy * kz;
        one = 64'd1 << 30;
        n = root_floor(one * one + a * a + b * b);
        my = norm_mag(a, n);
        mz = norm_mag(b, n);
        r.dx = (FRAC_BITS+1)'(norm_mag(one, n));
        r.dy = (FRAC_BITS+2)'(ny ? -my : my);
        r.dz = (FRAC_BITS+2)'(nz ? -mz : mz);
        return r;
    endfunction

    // Driver: present the next pixel word, hold it until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                pixel_t p;
                p = pixel_q.pop_front();
                i_valid   <= 1'b1;
                i_pixel_x <= p.px;
                i_pixel_y <= p.py;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Monitor: predict on pixel accept, check on ray accept.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) ray_q.push_back(predict_ray({i_pixel_x, i_pixel_y}));
            if (o_valid && i_ready) begin
                if (ray_q.size() == 0) begin
                    $error("unexpected ray word %0d %0d %0d", o_dir_x, o_dir_y, o_dir_z);
                    fail_count++;
                end else begin
                    ray_t e;
                    e = ray_q.pop_front();
                    if (o_dir_x !== e.dx) begin
                        $error("dir_x expected %0d actual %0d", e.dx, o_dir_x);
                        fail_count++;
                    end
                    if (o_dir_y !== e.dy) begin
                        $error("dir_y expected %0d actual %0d", $signed(e.dy), o_dir_y);
                        fail_count++;
                    end
                    if (o_dir_z !== e.dz) begin
                        $error("dir_z expected %0d actual %0d", $signed(e.dz), o_dir_z);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_WIDTH:   view_w  = data[9:0];
            REG_HEIGHT:  view_h  = data[9:0];
            REG_SCALE_Y: plane_y = data;
            default:     plane_z = data;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_view(int unsigned w, int unsigned h, int unsigned ky, int unsigned kz);
        // upper junk bits in the extent words must be ignored
        write_reg(REG_WIDTH,   {6'($urandom_range(63)), w[9:0]});
        write_reg(REG_HEIGHT,  {6'($urandom_range(63)), h[9:0]});
        write_reg(REG_SCALE_Y, ky[15:0]);
        write_reg(REG_SCALE_Z, kz[15:0]);
    endtask

    task automatic push_pixel(int unsigned x, int unsigned y);
        pixel_q.push_back({x[9:0], y[9:0]});
    endtask

    // Wait until every word is through, then let the pipe settle.
    task automatic drain;
        do @(negedge i_clk);
        while (pixel_q.size() != 0 || i_valid || ray_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int unsigned w, h;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_ready    = 1'b0;
        i_pixel_x  = '0;
        i_pixel_y  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_WIDTH;
        i_cfg_data = '0;
        view_w = 80; view_h = 24; plane_y = 28378; plane_z = 16384;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corners, center, edges and pixels outside the viewport.
        sender_idle_pct = 25; receiver_idle_pct = 46;
        push_pixel(0, 0);       push_pixel(1023, 1023);
        push_pixel(0, 1023);    push_pixel(1023, 0);
        push_pixel(40, 12);     push_pixel(80, 24);
        push_pixel(79, 23);     push_pixel(1, 1);
        push_pixel(200, 5);     push_pixel(41, 13);
        push_pixel(39, 11);     push_pixel(512, 512);
        drain();
        set_view(0, 0, 32768, 32768);        // zero extents act as one
        push_pixel(0, 0); push_pixel(1, 1); push_pixel(1023, 0);
        drain();
        set_view(1023, 1023, 65535, 40000);  // scales above one saturate
        push_pixel(0, 0); push_pixel(1023, 1023); push_pixel(511, 512);
        push_pixel(512, 511); push_pixel(0, 1023);
        drain();
        set_view(7, 3, 0, 0);                // zero scales: straight ahead
        push_pixel(0, 0); push_pixel(7, 3); push_pixel(3, 1);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph * 3 / N_PHASES)
                0: begin sender_idle_pct = 25; receiver_idle_pct = 46; end
                1: begin sender_idle_pct = 46; receiver_idle_pct = 25; end
                default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
            endcase
            case (ph % 4)
                0: set_view(1023, 1023, 32768, 32768);
                1: set_view(1, 1, $urandom_range(65535), $urandom_range(65535));
                2: set_view($urandom_range(1, 64), $urandom_range(1, 64),
                            $urandom_range(32768), $urandom_range(32768));
                default: set_view($urandom_range(1023), $urandom_range(1023),
                                  $urandom_range(32768), $urandom_range(32768));
            endcase
            w = (view_w == 0) ? 1 : view_w;
            h = (view_h == 0) ? 1 : view_h;
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                // mostly inside the viewport, the rest anywhere
                if ($urandom_range(9) < 7)
                    push_pixel($urandom_range(w), $urandom_range(h));
                else
                    push_pixel($urandom_range(1023), $urandom_range(1023));
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== pixel_to_ray_direction_top.f =====
+incdir+rtl
rtl/ptrd_pkg.sv
rtl/ptrd_div.sv
rtl/ptrd_sqrt.sv
rtl/pixel_to_ray_direction_top.sv
sim/testbench.sv
